// ----- rtl/core/qrb_pkg.sv -----
// shared constants, microcode types and the control store of the quadratic root finder
package qrb_pkg;

  // default word layout, signed fixed point
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // halving counter width and step counter width
  localparam int unsigned STEPS_W = 6;
  localparam int unsigned UPC_W   = 4;

  // stop reason codes
  localparam logic STOP_NARROW   = 1'b0;
  localparam logic STOP_RESIDUAL = 1'b1;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_INIT,
    OP_MUL_A,
    OP_ADD_B,
    OP_MUL_HI,
    OP_ADD_HI,
    OP_MUL_LO,
    OP_ADD_LO,
    OP_SIGN_LEFT,
    OP_DECIDE,
    OP_CHECK
  } op_e;

  // sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_PHASE,
    C_RESID,
    C_WIDTH
  } cond_e;

  // one control word
  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [UPC_W-1:0]   target;
  } uword_t;

  // program addresses
  localparam logic [UPC_W-1:0] U_INIT      = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_MUL_A     = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_ADD_B     = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_MUL_HI    = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_ADD_HI    = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_MUL_LO    = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_ADD_LO    = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_SIGN_LEFT = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_DECIDE    = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_CHECK     = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_LAST      = U_CHECK;

  // control store: evaluate f(left) once, then loop over check, evaluate, decide
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_INIT, cond: C_NEXT, target: U_INIT};
    case (upc)
      U_INIT:      w = '{op: OP_INIT,      cond: C_NEXT,  target: U_INIT};
      U_MUL_A:     w = '{op: OP_MUL_A,     cond: C_NEXT,  target: U_INIT};
      U_ADD_B:     w = '{op: OP_ADD_B,     cond: C_NEXT,  target: U_INIT};
      U_MUL_HI:    w = '{op: OP_MUL_HI,    cond: C_NEXT,  target: U_INIT};
      U_ADD_HI:    w = '{op: OP_ADD_HI,    cond: C_NEXT,  target: U_INIT};
      U_MUL_LO:    w = '{op: OP_MUL_LO,    cond: C_NEXT,  target: U_INIT};
      U_ADD_LO:    w = '{op: OP_ADD_LO,    cond: C_PHASE, target: U_DECIDE};
      U_SIGN_LEFT: w = '{op: OP_SIGN_LEFT, cond: C_GOTO,  target: U_CHECK};
      U_DECIDE:    w = '{op: OP_DECIDE,    cond: C_RESID, target: U_CHECK};
      U_CHECK:     w = '{op: OP_CHECK,     cond: C_WIDTH, target: U_MUL_A};
      default:     w = '{op: OP_CHECK,     cond: C_WIDTH, target: U_MUL_A};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/quadratic_root_bisection.sv -----
// bisection root finder for a fixed point quadratic, driven by a microcoded sequencer
//
// Usage: present coef_a/b/c and the interval ends with start_i; the item is taken on a
// clock edge where start_i is high and busy_o is low. busy_o stays high until the result
// is out. One result per item appears on root_o, steps_o and stop_reason_o for exactly
// one cycle, marked by done_o; the receiver cannot hold it off. A new item may be
// started in the cycle where done_o is shown.
// A run evaluates f(left) once, then halves the interval until it is narrow enough or
// the halving cap is hit, or until the residual test stops the run during a halving.
// Each halving runs 8 control words: check, the residual with three passes through the
// single 34 x 32 multiplier plus three adds, and decide.
// The user must write tolerance with cfg_we_i/cfg_wdata_i only while the block is idle;
// the block itself does not enforce this.
// Reset clears the sequencer and loads tolerance with round(0.001 * 2^FRAC_BITS).
module quadratic_root_bisection #(
  parameter int unsigned WORD_BITS = qrb_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = qrb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             cfg_we_i,
  input  logic [WORD_BITS-2:0]             cfg_wdata_i,
  input  logic signed [WORD_BITS-1:0]      coef_a_i,
  input  logic signed [WORD_BITS-1:0]      coef_b_i,
  input  logic signed [WORD_BITS-1:0]      coef_c_i,
  input  logic signed [WORD_BITS-1:0]      right_end_i,
  input  logic signed [WORD_BITS-1:0]      left_end_i,
  output logic                             done_o,
  output logic signed [WORD_BITS-1:0]      root_o,
  output logic [qrb_pkg::STEPS_W-1:0]      steps_o,
  output logic                             stop_reason_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned TOL_W = W - 1;
  // a*x + b*2^F
  localparam int unsigned TW    = ((2*W > W+FRAC_BITS) ? 2*W : W+FRAC_BITS) + 2;
  localparam int unsigned MA_W  = TW - W;
  localparam int unsigned PW    = MA_W + W;
  // f scaled by 2^(3F)
  localparam int unsigned ACC_W = ((3*W > W+2*FRAC_BITS) ? 3*W : W+2*FRAC_BITS) + 4;
  localparam int unsigned SW    = qrb_pkg::STEPS_W;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [SW-1:0]    MAX_STEPS = SW'(W + 8);

  // control registers
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          phase_q, phase_d;
  logic [qrb_pkg::UPC_W-1:0]     upc_q, upc_d;
  logic [TOL_W-1:0]              tol_q, tol_d;
  logic [SW-1:0]                 steps_q, steps_d;
  logic                          reason_q, reason_d;

  // datapath registers
  logic signed [W-1:0]           a_q, b_q, c_q;
  logic signed [W-1:0]           left_q, left_d, right_q, right_d;
  logic signed [W-1:0]           x_q, x_d, ev_q, ev_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [TW-1:0]          acc_q, acc_d;
  logic signed [ACC_W-1:0]       f_q, f_d;
  logic                          sl_neg_q, sl_neg_d, sl_zero_q, sl_zero_d;

  qrb_pkg::uword_t               uw;
  logic                          accept;
  logic                          finish;
  logic signed [W:0]             sum_lr, diff_lr;
  logic [W:0]                    width_lr;
  logic signed [W-1:0]           mid;
  logic                          stop_width;
  logic signed [ACC_W-1:0]       thr;
  logic                          f_small, f_neg, f_zero, flip;
  logic signed [MA_W-1:0]        ma;
  logic signed [PW-1:0]          mul_p;

  assign accept = start_i && !busy_q;
  assign uw     = qrb_pkg::ucode(upc_q);

  // midpoint and interval width
  assign sum_lr     = (W+1)'(left_q) + (W+1)'(right_q);
  assign mid        = sum_lr[W:1];
  assign diff_lr    = (W+1)'(right_q) - (W+1)'(left_q);
  assign width_lr   = diff_lr[W] ? (W+1)'(-diff_lr) : (W+1)'(diff_lr);
  assign stop_width = (width_lr <= (W+1)'(tol_q)) || (steps_q >= MAX_STEPS);

  // residual tests on the last evaluation
  assign thr     = ACC_W'(tol_q) <<< (2*FRAC_BITS);
  assign f_small = (f_q < thr) && (f_q > -thr);
  assign f_neg   = f_q[ACC_W-1];
  assign f_zero  = (f_q == '0);
  assign flip    = !sl_zero_q && !f_zero && (sl_neg_q != f_neg);

  // shared multiplier operand select
  always_comb begin
    case (uw.op)
      qrb_pkg::OP_MUL_A:  ma = MA_W'(a_q);
      qrb_pkg::OP_MUL_HI: ma = acc_q[TW-1:W];
      qrb_pkg::OP_MUL_LO: ma = $signed(MA_W'({1'b0, acc_q[W-1:0]}));
      default:            ma = '0;
    endcase
  end

  assign mul_p = ma * ev_q;

  // sequencer: next step and end of run
  always_comb begin
    upc_d    = upc_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    reason_d = reason_q;
    finish   = 1'b0;
    if (accept) begin
      upc_d  = qrb_pkg::U_INIT;
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (uw.cond)
        qrb_pkg::C_NEXT:  upc_d = qrb_pkg::UPC_W'(upc_q + 1'b1);
        qrb_pkg::C_GOTO:  upc_d = uw.target;
        qrb_pkg::C_PHASE: upc_d = phase_q ? uw.target : qrb_pkg::UPC_W'(upc_q + 1'b1);
        qrb_pkg::C_RESID: begin
          upc_d = uw.target;
          if (f_small) begin
            finish   = 1'b1;
            reason_d = qrb_pkg::STOP_RESIDUAL;
          end
        end
        qrb_pkg::C_WIDTH: begin
          upc_d = uw.target;
          if (stop_width) begin
            finish   = 1'b1;
            reason_d = qrb_pkg::STOP_NARROW;
          end
        end
        default: upc_d = uw.target;
      endcase
      if (finish) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        upc_d  = qrb_pkg::U_INIT;
      end
    end
  end

  // datapath operations
  always_comb begin
    left_d    = left_q;
    right_d   = right_q;
    x_d       = x_q;
    ev_d      = ev_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    f_d       = f_q;
    sl_neg_d  = sl_neg_q;
    sl_zero_d = sl_zero_q;
    steps_d   = steps_q;
    phase_d   = phase_q;
    if (accept) begin
      left_d  = left_end_i;
      right_d = right_end_i;
      steps_d = '0;
      phase_d = 1'b0;
    end else if (busy_q) begin
      case (uw.op)
        qrb_pkg::OP_INIT: begin
          ev_d = left_q;
          x_d  = mid;
        end
        qrb_pkg::OP_MUL_A, qrb_pkg::OP_MUL_HI, qrb_pkg::OP_MUL_LO: prod_d = mul_p;
        qrb_pkg::OP_ADD_B: acc_d = TW'(prod_q) + (TW'(b_q) <<< FRAC_BITS);
        qrb_pkg::OP_ADD_HI: f_d = (ACC_W'(prod_q) <<< W) + (ACC_W'(c_q) <<< (2*FRAC_BITS));
        qrb_pkg::OP_ADD_LO: f_d = f_q + ACC_W'(prod_q);
        qrb_pkg::OP_SIGN_LEFT: begin
          sl_neg_d  = f_neg;
          sl_zero_d = f_zero;
          phase_d   = 1'b1;
        end
        qrb_pkg::OP_DECIDE: begin
          if (!f_small) begin
            if (flip) begin
              right_d = x_q;
            end else begin
              left_d    = x_q;
              sl_neg_d  = f_neg;
              sl_zero_d = f_zero;
            end
            steps_d = SW'(steps_q + 1'b1);
          end
        end
        qrb_pkg::OP_CHECK: begin
          if (!stop_width) begin
            x_d  = mid;
            ev_d = mid;
          end
        end
        default: ;
      endcase
    end
  end

  // tolerance register
  always_comb begin
    tol_d = tol_q;
    if (cfg_we_i) begin
      tol_d = cfg_wdata_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      phase_q  <= 1'b0;
      upc_q    <= qrb_pkg::U_INIT;
      tol_q    <= TOL_RST;
      steps_q  <= '0;
      reason_q <= qrb_pkg::STOP_NARROW;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      phase_q  <= phase_d;
      upc_q    <= upc_d;
      tol_q    <= tol_d;
      steps_q  <= steps_d;
      reason_q <= reason_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= coef_a_i;
      b_q <= coef_b_i;
      c_q <= coef_c_i;
    end
    left_q    <= left_d;
    right_q   <= right_d;
    x_q       <= x_d;
    ev_q      <= ev_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    f_q       <= f_d;
    sl_neg_q  <= sl_neg_d;
    sl_zero_q <= sl_zero_d;
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign root_o        = x_q;
  assign steps_o       = steps_q;
  assign stop_reason_o = reason_q;

  // a result only follows a run
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q))
    else $error("result strobe without a run");

  // an accepted item starts a run
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_q && upc_q == qrb_pkg::U_INIT))
    else $error("accepted item did not start the sequencer");

  // step counter stays inside the program
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (upc_q <= qrb_pkg::U_LAST))
    else $error("step counter outside the control store");

  // halving count never passes the cap
  a_steps_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (steps_o <= MAX_STEPS))
    else $error("halving count beyond cap");

  // a width stop below the cap means the interval really is narrow
  a_width_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && stop_reason_o == qrb_pkg::STOP_NARROW && steps_o != MAX_STEPS)
      |-> (width_lr <= (W+1)'(tol_q)))
    else $error("width stop with a wide interval");

endmodule

// ----- bench/quadratic_root_bisection_tb.sv -----
// testbench for the quadratic root finder: directed and random items against a predictor
module quadratic_root_bisection_tb;

  localparam int unsigned W = qrb_pkg::WORD_BITS_DEF;
  localparam int unsigned F = qrb_pkg::FRAC_BITS_DEF;
  localparam int unsigned HALVING_CAP = W + 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic [W-2:0] TOL_RESET = (W-1)'(((64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [W-2:0] TOL_MAX   = '1;

  localparam logic signed [W-1:0] ONE   = 1 << F;
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    logic signed [W-1:0] right_end;
    logic signed [W-1:0] left_end;
  } quad_item_t;

  typedef struct {
    logic signed [W-1:0]         root;
    logic [qrb_pkg::STEPS_W-1:0] steps;
    logic                        stop_reason;
  } root_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        cfg_we_i;
  logic [W-2:0]                cfg_wdata_i;
  logic signed [W-1:0]         coef_a_i;
  logic signed [W-1:0]         coef_b_i;
  logic signed [W-1:0]         coef_c_i;
  logic signed [W-1:0]         right_end_i;
  logic signed [W-1:0]         left_end_i;
  logic                        done_o;
  logic signed [W-1:0]         root_o;
  logic [qrb_pkg::STEPS_W-1:0] steps_o;
  logic                        stop_reason_o;

  // predictor state and expected roots
  logic [W-2:0]  tol_model;
  root_result_t  root_q[$];
  root_result_t  due_root;
  int unsigned   mismatches;
  bit            no_gaps;

  quadratic_root_bisection #(
    .WORD_BITS(W),
    .FRAC_BITS(F)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coef_a_i     (coef_a_i),
    .coef_b_i     (coef_b_i),
    .coef_c_i     (coef_c_i),
    .right_end_i  (right_end_i),
    .left_end_i   (left_end_i),
    .done_o       (done_o),
    .root_o       (root_o),
    .steps_o      (steps_o),
    .stop_reason_o(stop_reason_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // f(x) scaled by 2^(3*F), wide enough to stay exact
  function automatic logic signed [127:0] quad_at(quad_item_t it, longint x);
    logic signed [127:0] wa, wb, wc, wx;
    wa = 128'(it.a);
    wb = 128'(it.b);
    wc = 128'(it.c);
    wx = 128'(x);
    return wa * wx * wx + ((wb * wx) <<< F) + (wc <<< (2 * F));
  endfunction

  function automatic int sign_of(logic signed [127:0] v);
    if (v < 0) return -1;
    return (v == 0) ? 0 : 1;
  endfunction

  // bisection on one item: floor midpoint, residual test, then halve toward the sign change
  function automatic root_result_t solve_bisection(quad_item_t it, logic [W-2:0] tol);
    root_result_t        res;
    longint              lft, rgt, mid, width, tol_l;
    logic signed [127:0] f_mid, thr;
    int unsigned         n;
    logic                why;
    lft   = longint'(it.left_end);
    rgt   = longint'(it.right_end);
    tol_l = longint'(tol);
    thr   = 128'(tol);
    thr   = thr <<< (2 * F);
    mid   = (lft + rgt) >>> 1;
    n     = 0;
    why   = qrb_pkg::STOP_NARROW;
    forever begin
      width = rgt - lft;
      if (width < 0) width = -width;
      if (width <= tol_l || n >= HALVING_CAP) break;
      mid   = (lft + rgt) >>> 1;
      f_mid = quad_at(it, mid);
      if (((f_mid < 0) ? -f_mid : f_mid) < thr) begin
        why = qrb_pkg::STOP_RESIDUAL;
        break;
      end
      if (sign_of(quad_at(it, lft)) * sign_of(f_mid) < 0) rgt = mid;
      else lft = mid;
      n++;
    end
    res.root        = W'(mid);
    res.steps       = n[qrb_pkg::STEPS_W-1:0];
    res.stop_reason = why;
    return res;
  endfunction

  function automatic quad_item_t mk_item(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                         logic signed [W-1:0] c, logic signed [W-1:0] lft,
                                         logic signed [W-1:0] rgt);
    quad_item_t it;
    it.a         = a;
    it.b         = b;
    it.c         = c;
    it.left_end  = lft;
    it.right_end = rgt;
    return it;
  endfunction

  // random word of random significant width, sign extended
  function automatic logic signed [W-1:0] rand_word();
    int unsigned         keep;
    logic signed [W-1:0] v;
    keep = $urandom_range(1, W);
    v    = $urandom;
    return (v <<< (W - keep)) >>> (W - keep);
  endfunction

  function automatic logic signed [W-1:0] extreme_word();
    case ($urandom_range(0, 5))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return '1;
      4: return ONE;
      default: return rand_word();
    endcase
  endfunction

  // mostly quadratics with known roots and an interval near one of them, some noise
  function automatic quad_item_t random_item();
    quad_item_t  it;
    longint      k, r1, r2, lo, hi;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      k  = longint'($urandom_range(0, 16)) - 8;
      if (k == 0) k = 1;
      r1 = (longint'($urandom_range(0, 20480)) - 10240) <<< 8;
      r2 = (longint'($urandom_range(0, 20480)) - 10240) <<< 8;
      it.a = W'(k <<< F);
      it.b = W'(-k * (r1 + r2));
      it.c = W'((k * r1 * r2) >>> F);
      if (kind < 2) begin
        lo = longint'(rand_word());
        hi = longint'(rand_word());
      end else begin
        lo = r1 - longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
        hi = r1 + longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
      end
      if ($urandom_range(0, 1) == 0) begin
        it.left_end  = W'(lo);
        it.right_end = W'(hi);
      end else begin
        it.left_end  = W'(hi);
        it.right_end = W'(lo);
      end
    end else if (kind < 17) begin
      it = mk_item(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    end else begin
      it = mk_item(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
                   extreme_word());
    end
    return it;
  endfunction

  // present one item after a random gap and wait until it is taken
  task automatic send_item(quad_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coef_a_i    <= it.a;
    coef_b_i    <= it.b;
    coef_c_i    <= it.c;
    right_end_i <= it.right_end;
    left_end_i  <= it.left_end;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    root_q.push_back(solve_bisection(it, tol_model));
  endtask

  // stop sending and wait for every pending root
  task automatic settle(int unsigned extra);
    start_i <= 1'b0;
    while (root_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [W-2:0] v);
    settle(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tol_model    = v;
  endtask

  task automatic flag_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (root_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with no item pending, root %h steps %0d reason %0d",
                   $time, root_o, steps_o, stop_reason_o);
      end else begin
        due_root = root_q.pop_front();
        if (root_o !== due_root.root) flag_field("root", due_root.root, root_o);
        if (steps_o !== due_root.steps) flag_field("steps", W'(due_root.steps), W'(steps_o));
        if (stop_reason_o !== due_root.stop_reason)
          flag_field("stop_reason", W'(due_root.stop_reason), W'(stop_reason_o));
      end
    end
  end

  // corner items at the reset tolerance
  task automatic test_directed();
    // zero polynomial stops on the residual at once
    send_item(mk_item('0, '0, '0, -ONE, ONE));
    // field extremes, full range both ways
    send_item(mk_item(W_MAX, W_MAX, W_MAX, W_MIN, W_MAX));
    send_item(mk_item(W_MIN, W_MIN, W_MIN, W_MAX, W_MIN));
    send_item(mk_item(W_MAX, W_MIN, '0, '0, W_MAX));
    send_item(mk_item('1, '1, '1, -ONE, ONE));
    // equal ends and ends within the tolerance: loop never runs; then ends just past it
    send_item(mk_item(ONE, '0, -4 * ONE, 5 * ONE, 5 * ONE));
    send_item(mk_item(ONE, '0, '0, '0, 1));
    send_item(mk_item(ONE, '0, '0, -3, 0));
    send_item(mk_item(ONE, '0, -ONE, '0, W'(TOL_RESET)));
    send_item(mk_item(ONE, '0, -ONE, '0, W'(TOL_RESET) + 1));
    // linear function
    send_item(mk_item('0, ONE, -ONE, -8 * ONE, 8 * ONE));
    // root exactly at the first midpoint
    send_item(mk_item(ONE, '0, -4 * ONE, '0, 4 * ONE));
    // f(left) is zero, so the left end moves
    send_item(mk_item(ONE, '0, -4 * ONE, -2 * ONE, 10 * ONE));
    // no sign change on the interval, in both orders
    send_item(mk_item(ONE, '0, ONE, -3 * ONE, 5 * ONE));
    send_item(mk_item(ONE, '0, ONE, 5 * ONE, -3 * ONE));
    // roots at plus and minus 40 over the whole range
    send_item(mk_item(ONE, '0, -1600 * ONE, W_MIN, W_MAX));
    send_item(mk_item(-ONE, '0, 1600 * ONE, W_MAX, W_MIN));
  endtask

  // zero tolerance: the interval stalls and the halving cap ends the run
  task automatic test_step_cap();
    write_tolerance('0);
    send_item(mk_item(ONE, '0, -2 * ONE, '0, 2 * ONE));
    send_item(mk_item(ONE, '0, -2 * ONE, 2 * ONE, '0));
    send_item(mk_item('0, '0, '0, -ONE, ONE));
    send_item(mk_item(W_MAX, W_MAX, W_MAX, W_MIN, W_MAX));
    repeat (6) send_item(random_item());
  endtask

  // smallest nonzero and largest tolerance
  task automatic test_tolerance_extremes();
    write_tolerance((W-1)'(1));
    repeat (12) send_item(random_item());
    write_tolerance(TOL_MAX);
    send_item(mk_item(ONE, '0, -1600 * ONE, W_MIN, W_MAX));
    send_item(mk_item(W_MIN, W_MAX, '0, W_MAX, W_MIN));
    repeat (12) send_item(random_item());
  endtask

  // random items under several tolerance settings, with and without gaps
  task automatic test_random();
    logic [W-2:0] tol_set[5];
    tol_set[0] = TOL_RESET;
    tol_set[1] = (W-1)'(1);
    tol_set[2] = (W-1)'(655);
    tol_set[3] = (W-1)'(65536);
    tol_set[4] = (W-1)'($urandom_range(1, 1 << 20));
    foreach (tol_set[p]) begin
      write_tolerance(tol_set[p]);
      for (int i = 0; i < 120; i++) begin
        if (i % 24 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_item(random_item());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    coef_a_i    = '0;
    coef_b_i    = '0;
    coef_c_i    = '0;
    right_end_i = '0;
    left_end_i  = '0;
    tol_model   = TOL_RESET;
    mismatches  = 0;
    no_gaps     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_cap();
    test_tolerance_extremes();
    test_random();
    settle(DRAIN_CYCLES);
    if (mismatches == 0 && root_q.size() == 0) begin
      $display("[quadratic_root_bisection] OK");
    end else begin
      $display("[quadratic_root_bisection] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[quadratic_root_bisection] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/qrb_pkg.sv
rtl/core/quadratic_root_bisection.sv
bench/quadratic_root_bisection_tb.sv
